// File: rtl/mme_pkg.sv
package mme_pkg;

   // Array geometry and element format.
   localparam int MAX_DIM      = 8;
   localparam int ELEM_BITS    = 16;
   localparam int FRAC_BITS    = ELEM_BITS / 2;
   localparam int PROD_BITS    = 2 * ELEM_BITS;
   localparam int OUT_BITS     = 35;
   localparam int IDX_BITS     = 3;
   localparam int DIM_BITS     = 4;
   localparam int ADDR_BITS    = $clog2(MAX_DIM * MAX_DIM);
   localparam int OP_BITS      = 2;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(8);
   localparam logic [DIM_BITS-1:0] DIM_MAX   = DIM_BITS'(MAX_DIM);

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_A_ROWS = 3'd0,
      CSR_A_COLS = 3'd1,
      CSR_B_ROWS = 3'd2,
      CSR_B_COLS = 3'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Store write strobes for a load transaction.
   typedef struct packed {
      logic wr_a;
      logic wr_b;
   } load_type;

   // One multiply-accumulate step issued by the controller.
   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last_k;
      logic                mism;
      logic                last_entry;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
      logic [IDX_BITS-1:0] inner;
   } cmd_type;

   typedef struct packed {
      logic done;
   } sts_type;

   // Clamp a dimension register to the range 1..MAX_DIM.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] value);
      logic [DIM_BITS-1:0] result;
      if (value == '0) begin
         result = DIM_BITS'(1);
      end else if (value > DIM_MAX) begin
         result = DIM_MAX;
      end else begin
         result = value;
      end
      return result;
   endfunction

   function automatic logic [ADDR_BITS-1:0] addr_of(input logic [IDX_BITS-1:0] row,
                                                    input logic [IDX_BITS-1:0] col);
      return ADDR_BITS'(int'(row) * MAX_DIM + int'(col));
   endfunction

endpackage

// File: rtl/mme_ctrl.sv
module mme_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mme_pkg::OP_BITS-1:0]        req_op,
   input  logic [mme_pkg::IDX_BITS-1:0]       req_row_index,
   input  logic [mme_pkg::IDX_BITS-1:0]       req_col_index,
   input  logic                               csr_wr_en,
   input  logic [mme_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mme_pkg::DIM_BITS-1:0]       csr_wdata,
   input  mme_pkg::sts_type                   sts,
   output logic                               busy,
   output mme_pkg::load_type                  load,
   output mme_pkg::cmd_type                   cmd
);
   import mme_pkg::*;

   state_type state_ff, state_in;

   logic [DIM_BITS-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [DIM_BITS-1:0] ar, ac, br, bc;
   logic [IDX_BITS-1:0] i_ff, j_ff, k_ff;
   logic [IDX_BITS-1:0] i_in, j_in, k_in;
   logic                mism_ff, mism_in;
   logic                accept, in_range;
   logic                k_last, j_last, i_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= DIM_RESET;
         a_cols_ff <= DIM_RESET;
         b_rows_ff <= DIM_RESET;
         b_cols_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_A_ROWS: a_rows_ff <= csr_wdata;
            CSR_A_COLS: a_cols_ff <= csr_wdata;
            CSR_B_ROWS: b_rows_ff <= csr_wdata;
            CSR_B_COLS: b_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      ar       = clamp_dim(a_rows_ff);
      ac       = clamp_dim(a_cols_ff);
      br       = clamp_dim(b_rows_ff);
      bc       = clamp_dim(b_cols_ff);
      accept   = start && (state_ff == ST_IDLE);
      in_range = ({1'b0, req_row_index} < DIM_MAX) && ({1'b0, req_col_index} < DIM_MAX);
      // In mismatch mode every entry is a single pass that copies A.
      k_last   = mism_ff || ({1'b0, k_ff} == ac - DIM_BITS'(1));
      j_last   = mism_ff ? ({1'b0, j_ff} == ac - DIM_BITS'(1))
                         : ({1'b0, j_ff} == bc - DIM_BITS'(1));
      i_last   = ({1'b0, i_ff} == ar - DIM_BITS'(1));
   end

   // Loop counters.
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      mism_in = mism_ff;
      if (state_ff == ST_IDLE) begin
         i_in    = '0;
         j_in    = '0;
         k_in    = '0;
         mism_in = (ac != br);
      end else if (state_ff == ST_RUN) begin
         if (k_last) begin
            k_in = '0;
            if (j_last) begin
               j_in = '0;
               i_in = i_ff + IDX_BITS'(1);
            end else begin
               j_in = j_ff + IDX_BITS'(1);
            end
         end else begin
            k_in = k_ff + IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         mism_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         mism_ff  <= mism_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_COMPUTE)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (k_last && j_last && i_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      busy           = (state_ff != ST_IDLE);
      load.wr_a      = accept && in_range && (req_op == OP_LOAD_A);
      load.wr_b      = accept && in_range && (req_op == OP_LOAD_B);
      cmd.valid      = (state_ff == ST_RUN);
      cmd.first      = (k_ff == '0);
      cmd.last_k     = k_last;
      cmd.mism       = mism_ff;
      cmd.last_entry = k_last && j_last && i_last;
      cmd.row        = i_ff;
      cmd.col        = j_ff;
      cmd.inner      = mism_ff ? j_ff : k_ff;
   end

endmodule

// File: rtl/mme_datapath.sv
module mme_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mme_pkg::load_type                       load,
   input  mme_pkg::cmd_type                        cmd,
   input  logic [mme_pkg::IDX_BITS-1:0]            req_row_index,
   input  logic [mme_pkg::IDX_BITS-1:0]            req_col_index,
   input  logic signed [mme_pkg::ELEM_BITS-1:0]    req_element,
   output mme_pkg::sts_type                        sts,
   output logic                                    rsp_strobe,
   output logic [mme_pkg::IDX_BITS-1:0]            rsp_out_row,
   output logic [mme_pkg::IDX_BITS-1:0]            rsp_out_col,
   output logic signed [mme_pkg::OUT_BITS-1:0]     rsp_out_value,
   output logic                                    rsp_mismatch,
   output logic                                    rsp_last
);
   import mme_pkg::*;

   logic signed [ELEM_BITS-1:0] a_mem [MAX_DIM*MAX_DIM];
   logic signed [ELEM_BITS-1:0] b_mem [MAX_DIM*MAX_DIM];

   logic [ADDR_BITS-1:0]        wr_addr, a_addr, b_addr;
   logic signed [ELEM_BITS-1:0] a_rd_ff, b_rd_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [OUT_BITS-1:0]  acc_ff, acc_in;
   cmd_type                     s1_ff, s2_ff;

   logic                        strobe_ff, last_ff, mism_ff;
   logic [IDX_BITS-1:0]         row_ff, col_ff;
   logic signed [OUT_BITS-1:0]  value_ff;

   assign wr_addr = addr_of(req_row_index, req_col_index);
   assign a_addr  = addr_of(cmd.row, cmd.inner);
   assign b_addr  = addr_of(cmd.inner, cmd.col);

   always_ff @(posedge clock) begin
      if (load.wr_a) begin
         a_mem[wr_addr] <= req_element;
      end
      if (cmd.valid) begin
         a_rd_ff <= a_mem[a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load.wr_b) begin
         b_mem[wr_addr] <= req_element;
      end
      if (cmd.valid) begin
         b_rd_ff <= b_mem[b_addr];
      end
   end

   // A copy in mismatch mode moves the element up to the product's fraction point.
   always_comb begin
      if (s1_ff.mism) begin
         prod_in = PROD_BITS'(a_rd_ff) <<< FRAC_BITS;
      end else begin
         prod_in = PROD_BITS'(a_rd_ff) * PROD_BITS'(b_rd_ff);
      end
      if (s2_ff.first) begin
         acc_in = OUT_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff + OUT_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid && s2_ff.last_k) begin
         value_ff <= acc_in;
         row_ff   <= s2_ff.row;
         col_ff   <= s2_ff.col;
         mism_ff  <= s2_ff.mism;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff     <= '0;
         s2_ff     <= '0;
         acc_ff    <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         s1_ff     <= cmd;
         s2_ff     <= s1_ff;
         if (s2_ff.valid) begin
            acc_ff <= acc_in;
         end
         strobe_ff <= s2_ff.valid && s2_ff.last_k;
         last_ff   <= s2_ff.valid && s2_ff.last_k && s2_ff.last_entry;
      end
   end

   assign sts.done      = strobe_ff && last_ff;
   assign rsp_strobe    = strobe_ff;
   assign rsp_last      = last_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_value = value_ff;
   assign rsp_mismatch  = mism_ff;

endmodule

// File: rtl/matrix_multiply_engine_top.sv
// Dense matrix multiply engine. A transaction is accepted when start is high and busy is
// low. Load transactions (op 0 for A, op 1 for B) write one Q8.8 element into a 64-entry
// store and return nothing, so loads can follow each other every cycle.
// A compute transaction (op 2) raises busy and walks the stores with one shared
// multiply-accumulate unit, one product per cycle through a read, multiply and accumulate
// pipeline. When a_cols differs from b_rows it instead copies A, one entry per cycle, with
// rsp_mismatch set. Result entries appear in row-major order, each for exactly one cycle
// with rsp_strobe high, and the final one carries rsp_last. The receiver cannot stall the
// engine, so it must take every strobed entry. The user must write the dimension registers
// through the csr port only while busy is low; the block itself does not enforce it. Zero
// counts as one and values above eight count as eight. Stores are not cleared at reset, so
// every element used by a compute must have been loaded first.
module matrix_multiply_engine_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [mme_pkg::OP_BITS-1:0]             req_op,
   input  logic [mme_pkg::IDX_BITS-1:0]            req_row_index,
   input  logic [mme_pkg::IDX_BITS-1:0]            req_col_index,
   input  logic signed [mme_pkg::ELEM_BITS-1:0]    req_element,
   output logic                                    rsp_strobe,
   output logic [mme_pkg::IDX_BITS-1:0]            rsp_out_row,
   output logic [mme_pkg::IDX_BITS-1:0]            rsp_out_col,
   output logic signed [mme_pkg::OUT_BITS-1:0]     rsp_out_value,
   output logic                                    rsp_mismatch,
   output logic                                    rsp_last,
   input  logic                                    csr_wr_en,
   input  logic [mme_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [mme_pkg::DIM_BITS-1:0]            csr_wdata
);
   import mme_pkg::*;

   load_type load;
   cmd_type  cmd;
   sts_type  sts;

   // The controller owns the dimension registers and the loop counters.
   mme_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_op        (req_op),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .sts           (sts),
      .busy          (busy),
      .load          (load),
      .cmd           (cmd)
   );

   // The datapath holds both stores, the multiplier, the accumulator and the result register.
   mme_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .cmd           (cmd),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_element   (req_element),
      .sts           (sts),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_mismatch  (rsp_mismatch),
      .rsp_last      (rsp_last)
   );

   // Results only appear during a compute transaction.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a compute transaction");

   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last mark without a result strobe");

   // The final entry ends the transaction.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !busy)
      else $error("engine still busy after the final entry");

   // Adjacent entries always belong to one run and share its mode.
   a_mode_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe)) |-> (rsp_mismatch == $past(rsp_mismatch)))
      else $error("mismatch flag changed within a run");

endmodule
